@@ rtl/core/toc_pkg.sv @@
// Package for the timed output channel bank: command codes and default sizes.
`timescale 1ns / 1ps
package toc_pkg;

  localparam int DEF_CHANNELS       = 4;
  localparam int DEF_HOLD_COUNT     = 32000;
  localparam int DEF_TICKS_PER_UNIT = 10;

  localparam int MAX_REPORTS = 4;
  localparam int FUNC_W      = 3;
  localparam int CHAN_W      = 2;
  localparam int DUR_W       = 12;
  localparam int COUNT_W     = 16;
  localparam int LEVELS_W    = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_ON     = 3'd1,
    FN_OFF    = 3'd2,
    FN_TOGGLE = 3'd3,
    FN_TIMED  = 3'd4
  } func_t;

endpackage

@@ rtl/core/timed_output_channel_bank.sv @@
// Timed output channel bank: command/tick processing and change reports.
// An item waits in the input register until the report register is free;
// its first report is then shown from the report register.
// Throughput: one report per cycle while out_ready is high; an item holds the report
// register until its last report goes, so one item per cycle with <= 1 report each.
// Reset (rst_n low, synchronous): all levels off, nothing reported, every
// countdown at the hold value, both stages empty.
`timescale 1ns / 1ps
module timed_output_channel_bank
  import toc_pkg::*;
#(
  parameter int CHANNELS       = DEF_CHANNELS,
  parameter int HOLD_COUNT     = DEF_HOLD_COUNT,
  parameter int TICKS_PER_UNIT = DEF_TICKS_PER_UNIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [DUR_W-1:0]    in_duration,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAN_W-1:0]   out_report_channel,
  output logic                out_report_level,
  output logic [LEVELS_W-1:0] out_output_levels,
  output logic                out_last
);

  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_RAW = DUR_W + $clog2(TICKS_PER_UNIT + 1);
  localparam int PROD_W   = (PROD_RAW > COUNT_W) ? PROD_RAW : COUNT_W;
  localparam logic [COUNT_W-1:0] HOLD_V = COUNT_W'(HOLD_COUNT);
  localparam logic [PROD_W-1:0]  TPU_V  = PROD_W'(TICKS_PER_UNIT);
  localparam logic [PROD_W-1:0]  HOLD_P = PROD_W'(HOLD_COUNT);

  // input register
  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [CHAN_W-1:0]   s1_chan_r;
  logic [DUR_W-1:0]    s1_dur_r;

  // channel state
  logic [CHANNELS-1:0] level_r, level_nxt;
  logic [CHANNELS-1:0] reported_r, reported_nxt;
  logic [COUNT_W-1:0]  count_r [CHANNELS];
  logic [COUNT_W-1:0]  count_nxt [CHANNELS];

  // report register
  logic [CHANNELS-1:0] pend_r, pend_nxt;
  logic [CHANNELS-1:0] snap_r;
  logic [LEVELS_W-1:0] levels_r, levels_nxt;

  logic                job_free;
  logic                s1_adv;
  logic                out_fire;
  logic [IDX_W-1:0]    sel_idx;
  logic [CHANNELS-1:0] sel_bit;
  logic [CHANNELS-1:0] diff;
  logic [CHANNELS-1:0] pick;
  logic [2:0]          pick_cnt;
  logic [PROD_W-1:0]   prod;
  logic [COUNT_W-1:0]  timed_load;

  assign out_valid = |pend_r;
  assign out_fire  = out_valid && out_ready;
  assign out_last  = $onehot(pend_r);
  assign job_free  = !out_valid || (out_fire && out_last);
  assign s1_adv    = s1_valid_r && job_free;
  assign in_ready  = !s1_valid_r || job_free;

  // lowest pending channel
  always_comb begin
    sel_idx = '0;
    sel_bit = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel_idx = IDX_W'(i);
        sel_bit = '0;
        sel_bit[i] = 1'b1;
      end
    end
  end

  assign out_report_channel = CHAN_W'(sel_idx);
  assign out_report_level   = snap_r[sel_idx];
  assign out_output_levels  = levels_r;

  assign prod       = PROD_W'(s1_dur_r) * TPU_V;
  assign timed_load = (prod > HOLD_P) ? HOLD_V : COUNT_W'(prod);

  always_comb begin
    level_nxt = level_r;
    for (int i = 0; i < CHANNELS; i++) begin
      count_nxt[i] = count_r[i];
      if (s1_func_r == FN_TICK) begin
        if (!count_r[i][COUNT_W-1]) begin
          if (count_r[i] < HOLD_V) begin
            count_nxt[i] = count_r[i] - COUNT_W'(1);
          end
        end else begin
          level_nxt[i] = 1'b0;
        end
      end else if (i < 4 && {3'b000, s1_chan_r} == 5'(i)) begin
        case (s1_func_r)
          FN_ON: begin
            level_nxt[i] = 1'b1;
            count_nxt[i] = HOLD_V;
          end
          FN_OFF: begin
            level_nxt[i] = 1'b0;
            count_nxt[i] = HOLD_V;
          end
          FN_TOGGLE: begin
            level_nxt[i] = !level_r[i];
            count_nxt[i] = HOLD_V;
          end
          FN_TIMED: begin
            level_nxt[i] = 1'b1;
            count_nxt[i] = timed_load;
          end
          default: begin
            count_nxt[i] = count_r[i];
          end
        endcase
      end
    end
  end

  // first MAX_REPORTS changed channels, in channel order
  always_comb begin
    diff     = level_nxt ^ reported_r;
    pick     = '0;
    pick_cnt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (diff[i] && pick_cnt < 3'(MAX_REPORTS)) begin
        pick[i]  = 1'b1;
        pick_cnt = pick_cnt + 3'd1;
      end
    end
    reported_nxt = (reported_r & ~pick) | (level_nxt & pick);
    levels_nxt   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < LEVELS_W) begin
        levels_nxt[i] = level_nxt[i];
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (out_fire) begin
      pend_nxt = pend_r & ~sel_bit;
    end
    if (s1_adv) begin
      pend_nxt = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      level_r    <= '0;
      reported_r <= '0;
      pend_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= HOLD_V;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      pend_r <= pend_nxt;
      if (s1_adv) begin
        level_r    <= level_nxt;
        reported_r <= reported_nxt;
        for (int i = 0; i < CHANNELS; i++) begin
          count_r[i] <= count_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func_r <= in_func;
      s1_chan_r <= in_channel;
      s1_dur_r  <= in_duration;
    end
    if (s1_adv) begin
      snap_r   <= level_nxt;
      levels_r <= levels_nxt;
    end
  end

  a_report_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pend_r) <= MAX_REPORTS)
    else $error("more reports pending than allowed");

  a_report_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> reported_r[sel_idx] == snap_r[sel_idx])
    else $error("pending report disagrees with reported level");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last && !s1_valid_r) |=> !out_valid)
    else $error("report stage busy after last report with no item waiting");

endmodule

@@ verif/tb_timed_output_channel_bank.sv @@
// Testbench for the timed output channel bank: directed and random command streams.
`timescale 1ns / 1ps
module tb_timed_output_channel_bank;
  import toc_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STUCK_LIMIT     = 5000;

  typedef struct {
    logic [CHAN_W-1:0]   chan;
    logic                lvl;
    logic [LEVELS_W-1:0] levels;
    logic                last;
  } report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [CHAN_W-1:0]   in_channel = '0;
  logic [DUR_W-1:0]    in_duration = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAN_W-1:0]   out_report_channel;
  logic                out_report_level;
  logic [LEVELS_W-1:0] out_output_levels;
  logic                out_last;

  // channel model
  logic                      chan_on    [DEF_CHANNELS];
  logic                      chan_shown [DEF_CHANNELS];
  logic signed [COUNT_W-1:0] chan_count [DEF_CHANNELS];
  report_t                   pending_reports[$];

  int fail_cnt  = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  timed_output_channel_bank u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_channel         (in_channel),
    .in_duration        (in_duration),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_report_channel (out_report_channel),
    .out_report_level   (out_report_level),
    .out_output_levels  (out_output_levels),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_channels();
    for (int i = 0; i < DEF_CHANNELS; i++) begin
      chan_on[i]    = 1'b0;
      chan_shown[i] = 1'b0;
      chan_count[i] = COUNT_W'(DEF_HOLD_COUNT);
    end
  endfunction

  function automatic void apply_command(logic [FUNC_W-1:0] fn, logic [CHAN_W-1:0] ch,
                                        logic [DUR_W-1:0] dur);
    int                  loaded;
    int                  changes;
    int                  k;
    logic [LEVELS_W-1:0] lv;
    report_t             r;
    if (fn == FN_TICK) begin
      for (int i = 0; i < DEF_CHANNELS; i++) begin
        if (chan_count[i] >= 0) begin
          if (chan_count[i] < DEF_HOLD_COUNT) chan_count[i] = chan_count[i] - COUNT_W'(1);
        end else begin
          chan_on[i] = 1'b0;
        end
      end
    end else if (int'(ch) < DEF_CHANNELS) begin
      case (fn)
        FN_ON: begin
          chan_on[ch]    = 1'b1;
          chan_count[ch] = COUNT_W'(DEF_HOLD_COUNT);
        end
        FN_OFF: begin
          chan_on[ch]    = 1'b0;
          chan_count[ch] = COUNT_W'(DEF_HOLD_COUNT);
        end
        FN_TOGGLE: begin
          chan_on[ch]    = ~chan_on[ch];
          chan_count[ch] = COUNT_W'(DEF_HOLD_COUNT);
        end
        FN_TIMED: begin
          loaded = int'(dur) * DEF_TICKS_PER_UNIT;
          if (loaded > DEF_HOLD_COUNT) loaded = DEF_HOLD_COUNT;
          chan_on[ch]    = 1'b1;
          chan_count[ch] = COUNT_W'(loaded);
        end
        default: ;
      endcase
    end
    lv = '0;
    for (int i = 0; i < DEF_CHANNELS && i < LEVELS_W; i++) lv[i] = chan_on[i];
    changes = 0;
    for (int i = 0; i < DEF_CHANNELS; i++) if (chan_on[i] != chan_shown[i]) changes++;
    if (changes > MAX_REPORTS) changes = MAX_REPORTS;
    k = 0;
    for (int i = 0; i < DEF_CHANNELS && k < MAX_REPORTS; i++) begin
      if (chan_on[i] != chan_shown[i]) begin
        r.chan   = CHAN_W'(i);
        r.lvl    = chan_on[i];
        r.levels = lv;
        r.last   = (k == changes - 1);
        pending_reports.push_back(r);
        chan_shown[i] = chan_on[i];
        k++;
      end
    end
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] fn, logic [CHAN_W-1:0] ch,
                           logic [DUR_W-1:0] dur);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_channel  <= ch;
    in_duration <= dur;
    do @(posedge clk); while (!in_ready);
    apply_command(fn, ch, dur);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [FUNC_W-1:0] fn;
    logic [DUR_W-1:0]  dur;
    int                r;
    r = $urandom_range(99);
    if (r < 40)      fn = FN_TICK;
    else if (r < 50) fn = FN_ON;
    else if (r < 60) fn = FN_OFF;
    else if (r < 70) fn = FN_TOGGLE;
    else if (r < 93) fn = FN_TIMED;
    else if (r < 95) fn = FN_SPARE5;
    else if (r < 97) fn = FN_SPARE6;
    else             fn = FN_SPARE7;
    r = $urandom_range(99);
    if (r < 70)      dur = DUR_W'($urandom_range(8));
    else if (r < 90) dur = DUR_W'($urandom);
    else if (r < 95) dur = '1;
    else             dur = DUR_W'(3200);
    send_item(fn, CHAN_W'($urandom), dur);
  endtask

  task automatic test_directed();
    send_idle = 0;
    recv_idle = 0;
    send_item(FN_ON, 2'd0, '0);
    send_item(FN_ON, 2'd1, '1);
    send_item(FN_TOGGLE, 2'd1, '0);
    send_item(FN_TOGGLE, 2'd2, '0);
    send_item(FN_OFF, 2'd2, '0);
    send_item(FN_TIMED, 2'd3, '0);
    send_item(FN_TICK, 2'd0, '0);
    send_item(FN_TICK, 2'd1, '0);
    send_item(FN_TICK, 2'd2, '1);
    send_item(FN_TIMED, 2'd0, '1);
    send_item(FN_TIMED, 2'd1, 12'd1);
    send_item(FN_SPARE5, 2'd2, '0);
    send_item(FN_SPARE6, 2'd3, '1);
    send_item(FN_SPARE7, 2'd1, 12'd5);
    send_item(FN_TIMED, 2'd2, 12'd3200);
    send_item(FN_TIMED, 2'd3, 12'd3199);
    send_item(FN_TOGGLE, 2'd3, '0);
    send_item(FN_OFF, 2'd0, '0);
    send_item(FN_TICK, 2'd3, '0);
    send_item(FN_ON, 2'd3, '1);
    send_item(FN_OFF, 2'd3, 12'd2048);
    send_item(FN_TICK, 2'd0, '0);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n_items) send_random_item();
    wait_drained();
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_req++;
    repeat (40) send_random_item();
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : report_check
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: channel %0d level %0d", out_report_channel,
               out_report_level);
        fail_cnt++;
      end else begin
        want = pending_reports.pop_front();
        if (out_report_channel !== want.chan) begin
          $error("report_channel: expected %0d, got %0d", want.chan, out_report_channel);
          fail_cnt++;
        end
        if (out_report_level !== want.lvl) begin
          $error("report_level: expected %0d, got %0d", want.lvl, out_report_level);
          fail_cnt++;
        end
        if (out_output_levels !== want.levels) begin
          $error("output_levels: expected %h, got %h", want.levels, out_output_levels);
          fail_cnt++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    wait (rst_n);
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clear_channels();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(90, 0, 0);
    test_random(90, 48, 0);
    test_random(90, 0, 48);
    test_random(90, 36, 36);
    test_backpressure();
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
